### src/lpc_pkg.sv
// Shared types, constants and helpers for the local peak counter.
package lpc_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int VALUE_BITS  = 16;
  localparam int SIDE_BITS   = 7;
  localparam int COUNT_BITS  = 13;
  localparam int COL_BITS    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SLOT_BITS   = 2;
  localparam int STORE_DEPTH = 3 * MAX_SIDE;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;
  localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(2);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COL_BITS-1:0]          col_t;
  typedef logic [SLOT_BITS-1:0]         slot_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;

  localparam value_t OUTSIDE_VALUE = '1;

  // One classified item handed from the front to the back.
  typedef struct packed {
    value_t value;
    col_t   col;
    slot_t  cur_slot;
    slot_t  mid_slot;
    slot_t  old_slot;
    logic   judge;
    logic   up_valid;
    logic   col_last;
    logic   frame_last;
  } op_t;

  function automatic slot_t slot_inc(input slot_t s);
    return (s == LAST_SLOT) ? '0 : slot_t'(s + 1'b1);
  endfunction

  function automatic addr_t store_addr(input slot_t s, input col_t c);
    return ADDR_BITS'(int'(s) * MAX_SIDE + int'(c));
  endfunction

  function automatic col_t last_index(input logic [SIDE_BITS-1:0] side);
    if (side == '0) begin
      return '0;
    end else if (int'(side) > MAX_SIDE) begin
      return COL_BITS'(MAX_SIDE - 1);
    end
    return COL_BITS'(int'(side) - 1);
  endfunction

  function automatic logic is_peak(input value_t center, input value_t up,
                                   input value_t below, input value_t left,
                                   input value_t right);
    return (center > up) && (center > below) && (center > left) && (center > right);
  endfunction

endpackage

### src/lpc_ram.sv
// Generic RAM: one write port, two registered read ports.
module lpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/lpc_front.sv
// Front: takes pixel items, tracks raster position and classifies each item.
module lpc_front import lpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   clear,
  input  logic   pixel_valid,
  input  value_t pixel_value,
  output logic   pixel_stall,
  input  col_t   last_idx,
  input  logic   queue_full,
  output logic   push,
  output op_t    op
);

  col_t  column_index, column_index_next;
  col_t  row_index, row_index_next;
  slot_t oldest_row_slot, oldest_row_slot_next;
  slot_t mid_slot;

  assign pixel_stall = queue_full;
  assign push        = pixel_valid && !queue_full;
  assign mid_slot    = slot_inc(oldest_row_slot);

  always_comb begin
    op.value      = pixel_value;
    op.col        = column_index;
    op.old_slot   = oldest_row_slot;
    op.mid_slot   = mid_slot;
    op.cur_slot   = slot_inc(mid_slot);
    op.judge      = (row_index != '0);
    op.up_valid   = (row_index > col_t'(1));
    op.col_last   = (column_index == last_idx);
    op.frame_last = (column_index == last_idx) && (row_index == last_idx);

    column_index_next    = column_index;
    row_index_next       = row_index;
    oldest_row_slot_next = oldest_row_slot;
    if (push) begin
      if (op.frame_last) begin
        column_index_next    = '0;
        row_index_next       = '0;
        oldest_row_slot_next = '0;
      end else if (op.col_last) begin
        column_index_next    = '0;
        row_index_next       = col_t'(row_index + 1'b1);
        oldest_row_slot_next = mid_slot;
      end else begin
        column_index_next = col_t'(column_index + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      column_index    <= '0;
      row_index       <= '0;
      oldest_row_slot <= '0;
    end else begin
      column_index    <= column_index_next;
      row_index       <= row_index_next;
      oldest_row_slot <= oldest_row_slot_next;
    end
  end

endmodule

### src/lpc_queue.sv
// Short queue of classified items between front and back.
module lpc_queue import lpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic empty,
  output logic full
);

  op_t                  entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_BITS'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_BITS'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_BITS'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_BITS'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

### src/lpc_back.sv
// Back: line store, neighbor window, peak tally, end-of-frame row flush and result register.
module lpc_back import lpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  col_t                  last_idx,
  input  op_t                   head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  count_valid,
  output logic [COUNT_BITS-1:0] peak_count,
  input  logic                  count_stall
);

  logic hold, issue_sample, issue_flush;

  // flush sequencer
  logic  flushing;
  col_t  flush_col;
  slot_t flush_cur, flush_mid;
  logic  flush_upv;

  // line store ports
  logic   we;
  addr_t  waddr, raddr_a, raddr_b;
  value_t rdata_a, rdata_b;

  // issue stage
  logic   s1_valid, s1_judge, s1_upv, s1_col_last, s1_done;
  col_t   s1_col;
  value_t s1_below;

  // window of the previous column
  value_t w_left, w_center, w_up, w_below;

  logic                  [COUNT_BITS-1:0] peak_tally;
  logic                  [COUNT_BITS:0]   tally_sum;
  value_t                up_eff, last_left;
  logic                  hit_prev, hit_last;

  assign hold         = count_valid && count_stall;
  assign issue_flush  = flushing && !hold;
  assign issue_sample = !flushing && !empty && !hold;
  assign pop          = issue_sample;

  assign we    = issue_sample;
  assign waddr = store_addr(head.cur_slot, head.col);

  always_comb begin
    if (flushing) begin
      raddr_a = store_addr(flush_cur, flush_col);
      raddr_b = store_addr(flush_mid, flush_col);
    end else begin
      raddr_a = store_addr(head.mid_slot, head.col);
      raddr_b = store_addr(head.old_slot, head.col);
    end
  end

  lpc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (head.value),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_comb begin
    up_eff    = s1_upv ? rdata_b : OUTSIDE_VALUE;
    last_left = (s1_col == '0) ? OUTSIDE_VALUE : w_center;
    hit_prev  = s1_judge && (s1_col != '0) &&
                is_peak(w_center, w_up, w_below, w_left, rdata_a);
    hit_last  = s1_judge && s1_col_last &&
                is_peak(rdata_a, up_eff, s1_below, last_left, OUTSIDE_VALUE);
    tally_sum = {1'b0, peak_tally} + (COUNT_BITS + 1)'(hit_prev)
              + (COUNT_BITS + 1)'(hit_last);
    if (tally_sum > {1'b0, TALLY_MAX}) begin
      tally_sum = {1'b0, TALLY_MAX};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flushing    <= 1'b0;
      s1_valid    <= 1'b0;
      peak_tally  <= '0;
      count_valid <= 1'b0;
    end else begin
      s1_valid <= issue_sample || issue_flush;
      if (issue_sample && head.frame_last) begin
        flushing <= 1'b1;
      end else if (issue_flush && (flush_col == last_idx)) begin
        flushing <= 1'b0;
      end
      if (count_valid && !count_stall) begin
        count_valid <= 1'b0;
      end
      if (s1_valid) begin
        if (s1_done) begin
          peak_tally  <= '0;
          count_valid <= 1'b1;
        end else begin
          peak_tally <= tally_sum[COUNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_sample && head.frame_last) begin
      flush_col <= '0;
      flush_cur <= head.cur_slot;
      flush_mid <= head.mid_slot;
      flush_upv <= head.judge;
    end else if (issue_flush) begin
      flush_col <= col_t'(flush_col + 1'b1);
    end
    if (flushing) begin
      s1_judge    <= 1'b1;
      s1_upv      <= flush_upv;
      s1_col      <= flush_col;
      s1_col_last <= (flush_col == last_idx);
      s1_done     <= (flush_col == last_idx);
      s1_below    <= OUTSIDE_VALUE;
    end else begin
      s1_judge    <= head.judge;
      s1_upv      <= head.up_valid;
      s1_col      <= head.col;
      s1_col_last <= head.col_last;
      s1_done     <= 1'b0;
      s1_below    <= head.value;
    end
    if (s1_valid) begin
      w_left   <= last_left;
      w_center <= rdata_a;
      w_up     <= up_eff;
      w_below  <= s1_below;
      if (s1_done) begin
        peak_count <= tally_sum[COUNT_BITS-1:0];
      end
    end
  end

endmodule

### src/local_peak_counter_4nbr.sv
// Top level of the strict four-neighbor local peak counter.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------
//  pixel    | pixel_valid / pixel_stall | pixel_value  (16, signed)
//  count    | count_valid / count_stall | peak_count   (13)
//  config   | cfg_valid / cfg_ready     | side         (7)
//
// One pixel item per cycle while pixel_stall is low. The last item of a frame starts
// a row flush over every column in the back unit, during which queued items wait;
// count_valid rises once the flush has passed its last column.
// rst is synchronous; it clears the position counters, the tally and the queue.
// The line store needs no clearing. pixel_stall rises when the four-entry
// queue is full; count_stall holds the back unit while a count waits.
module local_peak_counter_4nbr import lpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  value_t                pixel_value,
  output logic                  count_valid,
  input  logic                  count_stall,
  output logic [COUNT_BITS-1:0] peak_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SIDE_BITS-1:0]  side
);

  logic [SIDE_BITS-1:0] side_reg;
  logic                 cfg_write;
  col_t                 last_idx;
  logic                 push, pop, empty, full;
  op_t                  push_op, head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign last_idx  = last_index(side_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg <= SIDE_BITS'(1);
    end else if (cfg_write) begin
      side_reg <= side;
    end
  end

  lpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .clear       (cfg_write),
    .pixel_valid (pixel_valid),
    .pixel_value (pixel_value),
    .pixel_stall (pixel_stall),
    .last_idx    (last_idx),
    .queue_full  (full),
    .push        (push),
    .op          (push_op)
  );

  lpc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  lpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .clear       (cfg_write),
    .last_idx    (last_idx),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .count_valid (count_valid),
    .peak_count  (peak_count),
    .count_stall (count_stall)
  );

endmodule
